[sv/phpf_pkg.sv]
`default_nettype none

package phpf_pkg;

    // field and register widths
    localparam int MODE_W   = 1;
    localparam int PIX_W    = 8;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int HGT_W    = 14;
    localparam int THR_W    = 8;
    localparam int INT_W    = 9;
    localparam int DEN_W    = 14;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    // projection count and smoothed widths
    localparam int CCNT_W = 8;
    localparam int RCNT_W = 9;
    localparam int SM_W   = 13;
    localparam logic [SM_W-1:0] SM_MAX = 13'd8191;

    // default geometry
    localparam int IMAGE_WIDTH_DEF  = 320;
    localparam int IMAGE_HEIGHT_DEF = 240;
    localparam int KERNEL_LEN_DEF   = 20;
    localparam int AXIS_PEAKS_DEF   = 16;
    localparam int OUT_LIMIT_DEF    = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY   = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] THR_RST = 8'd128;
    localparam logic [INT_W-1:0] INT_RST = 9'd1;
    localparam logic [DEN_W-1:0] DEN_RST = 14'd1500;

    // per-axis commands
    typedef struct packed {
        logic cnt_rd;
        logic cnt_wr;
        logic clr;
        logic swp;
        logic pk_rd;
        logic sm_rd;
    } t_ax_cmd;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rem_step;
        logic cnt_rd;
        logic cnt_wr;
        logic clr;
        logic n_rst;
        logic swp;
        logic pair_rst;
        logic pk_rd;
        logic sm_rd;
        logic eval;
        logic count;
        logic emit;
        logic pair_next;
        logic empty;
        logic found_rst;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rem_last;
        logic clr_last;
        logic swp_last;
        logic busy;
        logic pair_none;
        logic pair_last;
        logic qual;
        logic want;
        logic out_free;
        logic found_zero;
    } t_sts;

endpackage

`default_nettype wire

[sv/phpf_axis.sv]
`default_nettype none

module phpf_axis import phpf_pkg::*; #(
    parameter int LEN    = IMAGE_WIDTH_DEF,
    parameter int KLEN   = KERNEL_LEN_DEF,
    parameter int PEAKS  = AXIS_PEAKS_DEF,
    parameter int CNT_W  = CCNT_W,
    parameter int SWP_W  = 9,
    localparam int AW    = $clog2(LEN),
    localparam int PW    = (PEAKS > 1) ? $clog2(PEAKS) : 1,
    localparam int NPW   = $clog2(PEAKS + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_ax_cmd         i_cmd,
    input  wire logic [AW-1:0]   i_cnt_addr,
    input  wire logic [SWP_W-1:0] i_n,
    input  wire logic [PW-1:0]   i_pk_idx,
    input  wire logic [AW-1:0]   i_sm_addr,
    output logic [AW-1:0]        o_pk_val,
    output logic [SM_W-1:0]      o_sm_val,
    output logic [NPW-1:0]       o_npk,
    output logic                 o_busy
);

    localparam int SLEN   = LEN + KLEN - 1;
    localparam int SAW    = $clog2(SLEN);
    localparam int MRW    = $clog2(2 * SLEN);
    localparam int CMAX   = 2 ** CNT_W - 1;
    localparam int ACC_W0 = $clog2(CMAX * (KLEN + 1) + 1);
    localparam int ACC_W  = (ACC_W0 > SM_W) ? ACC_W0 : SM_W;

    logic [CNT_W-1:0] r_cnt_mem [LEN];
    logic [SM_W-1:0]  r_sm_mem  [SLEN];
    logic [AW-1:0]    r_pk_mem  [PEAKS];

    logic [CNT_W-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]    r_pk_rd;
    logic [SM_W-1:0]  r_sm_rd;

    logic             w_swp_ok, w_add, w_sub, w_clr_ok;
    logic [AW-1:0]    w_addr_a, w_addr_b;

    logic             r_s1_vld, r_s1_add, r_s1_sub;
    logic [SAW-1:0]   r_s1_idx;
    logic [ACC_W-1:0] r_acc, w_acc_base, w_acc_n;
    logic [SM_W-1:0]  w_val;

    logic             r_s2_vld;
    logic [SAW-1:0]   r_s2_idx;
    logic [SM_W-1:0]  r_s2_val;

    logic             r_rising;
    logic [NPW-1:0]   r_npk;
    logic [SM_W-1:0]  r_ref;
    logic [AW-1:0]    r_mq, w_map_nxt;
    logic [MRW-1:0]   r_mr, w_mr_sum, w_mr_nxt;
    logic             w_wrap, w_rec;

    // count memory addressing: pixel update or sliding window
    assign w_swp_ok = i_cmd.swp && (int'(i_n) < SLEN);
    assign w_add    = int'(i_n) < LEN;
    assign w_sub    = int'(i_n) >= KLEN;
    assign w_clr_ok = i_cmd.clr && (int'(i_n) < LEN);
    assign w_addr_a = i_cmd.cnt_rd ? i_cnt_addr : (w_add ? AW'(i_n) : '0);
    assign w_addr_b = w_sub ? AW'(int'(i_n) - KLEN) : '0;

    // count memory
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_cnt_mem[w_addr_a];
        r_rd_b <= r_cnt_mem[w_addr_b];
        if (w_clr_ok) begin
            r_cnt_mem[AW'(i_n)] <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_cnt_mem[i_cnt_addr] <= (r_rd_a == CNT_W'(CMAX)) ? r_rd_a : r_rd_a + 1'b1;
        end
    end

    // stage one: window read issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_swp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= SAW'(i_n);
        r_s1_add <= w_add;
        r_s1_sub <= w_sub;
    end

    // stage two: running window sum with saturation
    assign w_acc_base = (r_s1_idx == '0) ? '0 : r_acc;
    assign w_acc_n    = w_acc_base + (r_s1_add ? ACC_W'(r_rd_a) : '0)
                      - (r_s1_sub ? ACC_W'(r_rd_b) : '0);
    assign w_val      = (w_acc_n > ACC_W'(SM_MAX)) ? SM_MAX : SM_W'(w_acc_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_acc <= w_acc_n;
        end
        r_s2_idx <= r_s1_idx;
        r_s2_val <= w_val;
    end

    // stage three: index to image position, running quotient
    assign w_mr_sum  = r_mr + MRW'(LEN);
    assign w_wrap    = w_mr_sum >= MRW'(SLEN);
    assign w_map_nxt = w_wrap ? r_mq + 1'b1 : r_mq;
    assign w_mr_nxt  = w_wrap ? w_mr_sum - MRW'(SLEN) : w_mr_sum;
    assign w_rec     = r_s2_vld && (r_s2_idx != '0) && r_rising
                     && (r_s2_val < r_ref) && (int'(r_npk) < PEAKS);

    // falling edge scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rising <= 1'b1;
            r_npk    <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_idx == '0) begin
                r_rising <= 1'b1;
                r_npk    <= '0;
            end else if (r_rising) begin
                if (w_rec) begin
                    r_rising <= 1'b0;
                    r_npk    <= r_npk + 1'b1;
                end
            end else if (r_s2_val > r_ref) begin
                r_rising <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            if (r_s2_idx == '0) begin
                r_ref <= r_s2_val;
                r_mq  <= '0;
                r_mr  <= '0;
            end else begin
                r_mq <= w_map_nxt;
                r_mr <= w_mr_nxt;
                if (r_rising) begin
                    r_ref <= r_s2_val;
                end
            end
        end
    end

    // smoothed profile memory
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_sm_mem[r_s2_idx] <= r_s2_val;
        end
        if (i_cmd.sm_rd) begin
            r_sm_rd <= r_sm_mem[SAW'(i_sm_addr)];
        end
    end

    // peak position list
    always_ff @(posedge i_clk) begin
        if (w_rec) begin
            r_pk_mem[r_npk[PW-1:0]] <= w_map_nxt;
        end
        if (i_cmd.pk_rd) begin
            r_pk_rd <= r_pk_mem[i_pk_idx];
        end
    end

    assign o_pk_val = r_pk_rd;
    assign o_sm_val = r_sm_rd;
    assign o_npk    = r_npk;
    assign o_busy   = r_s1_vld | r_s2_vld;

endmodule

`default_nettype wire

[sv/phpf_dp.sv]
`default_nettype none

module phpf_dp import phpf_pkg::*; #(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
    parameter int KERNEL_LEN   = KERNEL_LEN_DEF,
    parameter int AXIS_PEAKS   = AXIS_PEAKS_DEF,
    parameter int OUT_LIMIT    = OUT_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire logic [COL_W-1:0]     i_column,
    input  wire logic [ROW_W-1:0]     i_row,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [COL_W-1:0]          o_peak_x,
    output logic [ROW_W-1:0]          o_peak_y,
    output logic [HGT_W-1:0]          o_peak_height,
    output logic                      o_valid_res,
    output logic                      o_truncated,
    output logic                      o_last
);

    localparam int CAW     = $clog2(IMAGE_WIDTH);
    localparam int RAW     = $clog2(IMAGE_HEIGHT);
    localparam int CSLEN   = IMAGE_WIDTH + KERNEL_LEN - 1;
    localparam int RSLEN   = IMAGE_HEIGHT + KERNEL_LEN - 1;
    localparam int SWP_LEN = (CSLEN > RSLEN) ? CSLEN : RSLEN;
    localparam int CLR_LEN = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int SWP_W   = $clog2(SWP_LEN);
    localparam int PW      = (AXIS_PEAKS > 1) ? $clog2(AXIS_PEAKS) : 1;
    localparam int NPW     = $clog2(AXIS_PEAKS + 1);
    localparam int FW      = $clog2(OUT_LIMIT + 2);
    localparam int RBW     = $clog2(COL_W);

    logic [THR_W-1:0] r_thr;
    logic [INT_W-1:0] r_int;
    logic [DEN_W-1:0] r_den;

    logic [PIX_W-1:0] r_pix;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [INT_W-1:0] r_rem, w_step;
    logic [INT_W:0]   w_rem_sh;
    logic [RBW-1:0]   r_rbit;
    logic             w_col_ok, w_row_ok, w_hit;

    logic [SWP_W-1:0] r_n;

    t_ax_cmd          w_col_cmd, w_row_cmd;
    logic [CAW-1:0]   w_col_addr, w_col_pk;
    logic [RAW-1:0]   w_row_addr, w_row_pk;
    logic [SM_W-1:0]  w_col_sm, w_row_sm;
    logic [NPW-1:0]   w_col_npk, w_row_npk;
    logic             w_col_busy, w_row_busy;

    logic [PW-1:0]    r_pi, r_pj;
    logic [CAW-1:0]   r_x;
    logic [RAW-1:0]   r_y;
    logic [HGT_W-1:0] r_h, w_h;
    logic             r_qual;
    logic [FW-1:0]    r_found, r_emit, w_total;
    logic             w_trunc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
            r_int <= INT_RST;
            r_den <= DEN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr <= THR_W'(i_cfg_wdata);
                CFG_INTERVAL:  r_int <= INT_W'(i_cfg_wdata);
                CFG_DENSITY:   r_den <= DEN_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_pixel;
            r_col <= i_column;
            r_row <= i_row;
        end
    end

    // column remainder by the sampling step, one bit a cycle
    assign w_step   = (r_int == '0) ? INT_W'(1) : r_int;
    assign w_rem_sh = {r_rem, r_col[r_rbit]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= '0;
            r_rbit <= RBW'(COL_W - 1);
        end else if (i_cmd.rem_step) begin
            r_rem  <= (w_rem_sh >= {1'b0, w_step}) ? INT_W'(w_rem_sh - {1'b0, w_step})
                                                  : INT_W'(w_rem_sh);
            r_rbit <= r_rbit - 1'b1;
        end
    end

    assign w_col_ok   = int'(r_col) < IMAGE_WIDTH;
    assign w_row_ok   = int'(r_row) < IMAGE_HEIGHT;
    assign w_hit      = w_col_ok && w_row_ok && (r_rem == '0) && (r_pix > r_thr);
    assign w_col_addr = w_col_ok ? CAW'(r_col) : '0;
    assign w_row_addr = w_row_ok ? RAW'(r_row) : '0;

    // sweep index for clearing and smoothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.n_rst) begin
            r_n <= '0;
        end else if (i_cmd.clr || i_cmd.swp) begin
            r_n <= r_n + 1'b1;
        end
    end

    // axis commands
    always_comb begin
        w_col_cmd.cnt_rd = i_cmd.cnt_rd;
        w_col_cmd.cnt_wr = i_cmd.cnt_wr & w_hit;
        w_col_cmd.clr    = i_cmd.clr;
        w_col_cmd.swp    = i_cmd.swp;
        w_col_cmd.pk_rd  = i_cmd.pk_rd;
        w_col_cmd.sm_rd  = i_cmd.sm_rd;
        w_row_cmd        = w_col_cmd;
    end

    phpf_axis #(
        .LEN   (IMAGE_WIDTH),
        .KLEN  (KERNEL_LEN),
        .PEAKS (AXIS_PEAKS),
        .CNT_W (CCNT_W),
        .SWP_W (SWP_W)
    ) u_col_axis (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_col_cmd),
        .i_cnt_addr (w_col_addr),
        .i_n        (r_n),
        .i_pk_idx   (r_pj),
        .i_sm_addr  (w_col_pk),
        .o_pk_val   (w_col_pk),
        .o_sm_val   (w_col_sm),
        .o_npk      (w_col_npk),
        .o_busy     (w_col_busy)
    );

    phpf_axis #(
        .LEN   (IMAGE_HEIGHT),
        .KLEN  (KERNEL_LEN),
        .PEAKS (AXIS_PEAKS),
        .CNT_W (RCNT_W),
        .SWP_W (SWP_W)
    ) u_row_axis (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_row_cmd),
        .i_cnt_addr (w_row_addr),
        .i_n        (r_n),
        .i_pk_idx   (r_pi),
        .i_sm_addr  (w_row_pk),
        .o_pk_val   (w_row_pk),
        .o_sm_val   (w_row_sm),
        .o_npk      (w_row_npk),
        .o_busy     (w_row_busy)
    );

    // pair walk: rows outer, columns inner
    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_rst) begin
            r_pi <= '0;
            r_pj <= '0;
        end else if (i_cmd.pair_next) begin
            if ((NPW'(r_pj) + NPW'(1)) == w_col_npk) begin
                r_pj <= '0;
                r_pi <= r_pi + 1'b1;
            end else begin
                r_pj <= r_pj + 1'b1;
            end
        end
    end

    // pair height and threshold
    assign w_h = HGT_W'(w_col_sm) + HGT_W'(w_row_sm);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_h    <= w_h;
            r_qual <= w_h > r_den;
            r_x    <= w_col_pk;
            r_y    <= w_row_pk;
        end
    end

    // qualifying pair count, held one above the limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.found_rst) begin
            r_found <= '0;
        end else if (i_cmd.count && r_qual && (int'(r_found) <= OUT_LIMIT)) begin
            r_found <= r_found + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_rst) begin
            r_emit <= '0;
        end else if (i_cmd.emit) begin
            r_emit <= r_emit + 1'b1;
        end
    end

    assign w_trunc = int'(r_found) > OUT_LIMIT;
    assign w_total = w_trunc ? FW'(OUT_LIMIT) : r_found;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.empty) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_peak_x      <= COL_W'(r_x);
            o_peak_y      <= ROW_W'(r_y);
            o_peak_height <= r_h;
            o_valid_res   <= 1'b1;
            o_truncated   <= w_trunc;
            o_last        <= (r_emit + 1'b1) == w_total;
        end else if (i_cmd.empty) begin
            o_peak_x      <= '0;
            o_peak_y      <= '0;
            o_peak_height <= '0;
            o_valid_res   <= 1'b0;
            o_truncated   <= 1'b0;
            o_last        <= 1'b1;
        end
    end

    // status
    always_comb begin
        o_sts.rem_last   = r_rbit == '0;
        o_sts.clr_last   = int'(r_n) == CLR_LEN - 1;
        o_sts.swp_last   = int'(r_n) == SWP_LEN - 1;
        o_sts.busy       = w_col_busy | w_row_busy;
        o_sts.pair_none  = (w_col_npk == '0) || (w_row_npk == '0);
        o_sts.pair_last  = ((NPW'(r_pi) + NPW'(1)) == w_row_npk)
                        && ((NPW'(r_pj) + NPW'(1)) == w_col_npk);
        o_sts.qual       = r_qual;
        o_sts.want       = r_qual && (r_emit < w_total);
        o_sts.out_free   = !o_out_valid || i_out_ready;
        o_sts.found_zero = r_found == '0;
    end

endmodule

`default_nettype wire

[sv/phpf_ctrl.sv]
`default_nettype none

module phpf_ctrl import phpf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_mode,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_REM    = 12'b0000_0000_0100,
        S_RD     = 12'b0000_0000_1000,
        S_WR     = 12'b0000_0001_0000,
        S_SMOOTH = 12'b0000_0010_0000,
        S_DRAIN  = 12'b0000_0100_0000,
        S_PA     = 12'b0000_1000_0000,
        S_PB     = 12'b0001_0000_0000,
        S_PC     = 12'b0010_0000_0000,
        S_PD     = 12'b0100_0000_0000,
        S_EMPTY  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   w_adv;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_adv      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_mode) begin
                        o_cmd.n_rst = 1'b1;
                        n_state     = S_SMOOTH;
                    end else begin
                        n_state = S_REM;
                    end
                end
            end
            S_REM: begin
                o_cmd.rem_step = 1'b1;
                if (i_sts.rem_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_SMOOTH: begin
                o_cmd.swp = 1'b1;
                if (i_sts.swp_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    o_cmd.pair_rst  = 1'b1;
                    o_cmd.found_rst = 1'b1;
                    n_pass          = 1'b0;
                    n_state         = i_sts.pair_none ? S_EMPTY : S_PA;
                end
            end
            S_PA: begin
                o_cmd.pk_rd = 1'b1;
                n_state     = S_PB;
            end
            S_PB: begin
                o_cmd.sm_rd = 1'b1;
                n_state     = S_PC;
            end
            S_PC: begin
                o_cmd.eval = 1'b1;
                n_state    = S_PD;
            end
            S_PD: begin
                // first pass counts, second pass emits
                if (!r_pass) begin
                    o_cmd.count = 1'b1;
                    w_adv       = 1'b1;
                end else if (!(i_sts.want && !i_sts.out_free)) begin
                    o_cmd.emit = i_sts.want;
                    w_adv      = 1'b1;
                end
                if (w_adv) begin
                    if (i_sts.pair_last) begin
                        if (!r_pass) begin
                            if (i_sts.found_zero && !i_sts.qual) begin
                                n_state = S_EMPTY;
                            end else begin
                                n_pass         = 1'b1;
                                o_cmd.pair_rst = 1'b1;
                                n_state        = S_PA;
                            end
                        end else begin
                            o_cmd.n_rst = 1'b1;
                            n_state     = S_CLEAR;
                        end
                    end else begin
                        o_cmd.pair_next = 1'b1;
                        n_state         = S_PA;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.empty = 1'b1;
                    o_cmd.n_rst = 1'b1;
                    n_state     = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/projection_histogram_peak_finder_top.sv]
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   i_mode i_pixel i_column i_row
// output    out        o_out_valid / i_out_ready o_peak_x o_peak_y o_peak_height
//                                                o_valid_res o_truncated o_last
// config    in         i_cfg_wr_en               i_cfg_index i_cfg_wdata
//
// a pixel word takes the column remainder by the sampling step one bit a cycle,
// then does a read-modify-write of both count memories
// a process word sweeps the smoothing window, drains the smoothing pipe, then
// walks the peak pairs through S_PA to S_PD in a counting pass and, unless no pair
// qualifies, an emitting pass that output stalls can hold, then clears the counts
// after reset the counts are cleared before the first word
`default_nettype none

module projection_histogram_peak_finder_top import phpf_pkg::*; #(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
    parameter int KERNEL_LEN   = KERNEL_LEN_DEF,
    parameter int AXIS_PEAKS   = AXIS_PEAKS_DEF,
    parameter int OUT_LIMIT    = OUT_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire logic [COL_W-1:0]     i_column,
    input  wire logic [ROW_W-1:0]     i_row,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COL_W-1:0]          o_peak_x,
    output logic [ROW_W-1:0]          o_peak_y,
    output logic [HGT_W-1:0]          o_peak_height,
    output logic                      o_valid_res,
    output logic                      o_truncated,
    output logic                      o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    phpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode[0]),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // projections, smoothing, peak pairs and output word
    phpf_dp #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .KERNEL_LEN   (KERNEL_LEN),
        .AXIS_PEAKS   (AXIS_PEAKS),
        .OUT_LIMIT    (OUT_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pixel       (i_pixel),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_peak_x      (o_peak_x),
        .o_peak_y      (o_peak_y),
        .o_peak_height (o_peak_height),
        .o_valid_res   (o_valid_res),
        .o_truncated   (o_truncated),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    // empty frame marker is a lone last word with zero payload
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_last && !o_truncated && o_peak_height == '0))
        else $error("empty marker malformed");

    // no new word is taken while a frame's results are still coming
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input taken in the middle of a result burst");

    // a reported pair exceeds a non-negative minimum, so its height is nonzero
    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_peak_height != '0))
        else $error("reported peak with zero height");
`endif

endmodule

`default_nettype wire
